// ===== rtl/core/cttbl_pkg.sv =====
`timescale 1ns / 1ps

package cttbl_pkg;

  // Operation codes carried by the func field
  typedef enum logic [2:0] {
    FN_INSERT     = 3'd0,
    FN_FIND_ID    = 3'd1,
    FN_FIND_OWNER = 3'd2,
    FN_REMOVE     = 3'd3,
    FN_HEAD       = 3'd4
  } func_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_NONE = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  // Sequencer states
  typedef enum logic {
    SEQ_IDLE = 1'b0,
    SEQ_BUSY = 1'b1
  } seq_state_t;

  // One table entry, also used as the search key
  typedef struct packed {
    logic [31:0] trans_id;
    logic [15:0] owner_tag;
  } entry_t;

  // Search and update controls shared by every cell
  typedef struct packed {
    logic search_en;  // compare this cycle
    logic by_id;      // compare transaction ids, else owner tags
    logic shift;      // pull down from the upper neighbor at and above the first hit
  } cell_ctl_t;

endpackage

// ===== rtl/core/compacting_transaction_table.sv =====
`timescale 1ns / 1ps

// Ordered, compacting table of active transactions.
// Input channel (in_valid / in_stall): one item carries func, trans_id and
// owner_tag. Insert appends at the active count, find by id or owner returns
// the first match in slot order, remove by owner deletes the first match and
// the later entries move down one slot, head returns slot 0.
// Result channel (out_valid / out_stall): exactly one result per item with
// status, slot, the entry concerned, the active count and an empty flag.
// Sequencing: an accepted item is held in func_r and key_r while the block is busy;
// the busy state does the parallel compare in the row of cells, the first-hit
// encode and the shift, and registers the result. No new item is taken while busy.
// A finished result waits in the output register; the next item is accepted
// meanwhile, and its update waits (in_stall high) while out_stall holds the
// earlier result.
// Reset clears the active count, sets table_size to 16 and drops any result.
// table_size is written over the APB port at any address with paddr[2] low; a write
// clamps the active count down to the new usable size.
module compacting_transaction_table
  import cttbl_pkg::*;
#(
  parameter int MAX_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_func,
  input  logic [31:0] in_trans_id,
  input  logic [15:0] in_owner_tag,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [3:0]  out_slot,
  output logic [31:0] out_found_trans_id,
  output logic [15:0] out_found_owner,
  output logic [4:0]  out_active_count,
  output logic        out_empty_res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CNT_W   = $clog2(MAX_SLOTS + 1);
  localparam int IDX_W   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CMP_W   = (CNT_W > 5) ? CNT_W : 5;
  localparam int SLOT_XW = (CNT_W > 4) ? CNT_W : 4;

  seq_state_t         state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [4:0]         table_size_r;
  logic [2:0]         func_r;
  entry_t             key_r;

  logic               out_valid_r, out_valid_nxt;
  status_t            status_r, status_nxt;
  logic [3:0]         slot_r, slot_nxt;
  entry_t             found_r, found_nxt;
  logic [4:0]         act_r, act_nxt;
  logic               empty_r, empty_nxt;

  logic               accept;
  logic               commit;
  logic               cfg_wr;
  logic [CNT_W-1:0]   usable_cur;
  logic [CNT_W-1:0]   usable_new;
  cell_ctl_t          ctl;
  logic [MAX_SLOTS-1:0] live;
  logic [MAX_SLOTS-1:0] load;
  logic [MAX_SLOTS-1:0] first;
  logic [MAX_SLOTS:0]   hit;
  entry_t             cell_entry [MAX_SLOTS];
  entry_t             hit_entry;
  logic [IDX_W-1:0]   hit_idx;
  logic               ins_ok;
  logic [SLOT_XW-1:0] cnt_slot_x;
  logic [SLOT_XW-1:0] idx_slot_x;
  logic [CMP_W-1:0]   cnt_act_x;

  // Saturate a table_size value to 1..MAX_SLOTS
  function automatic logic [CNT_W-1:0] usable_of(input logic [4:0] sz);
    logic [CMP_W-1:0] szx;
    logic [CMP_W-1:0] res;
    szx = CMP_W'(sz);
    if (szx == '0) begin
      res = CMP_W'(1);
    end else if (szx > CMP_W'(MAX_SLOTS)) begin
      res = CMP_W'(MAX_SLOTS);
    end else begin
      res = szx;
    end
    return res[CNT_W-1:0];
  endfunction

  assign usable_cur = usable_of(table_size_r);
  assign usable_new = usable_of(pwdata[4:0]);

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {27'd0, table_size_r} : 32'd0;

  // Handshake
  assign in_stall = (state_r == SEQ_BUSY);
  assign accept   = in_valid && !in_stall;

  // Commit the update unless the previous result is still stalled
  always_comb begin
    commit = (state_r == SEQ_BUSY) && !(out_valid_r && out_stall);
    ctl    = '0;
    if (state_r == SEQ_BUSY) begin
      ctl.by_id     = (func_r == FN_FIND_ID);
      ctl.search_en = (func_r == FN_FIND_ID) || (func_r == FN_FIND_OWNER) ||
                      (func_r == FN_REMOVE);
      ctl.shift     = commit && (func_r == FN_REMOVE);
    end
  end

  // Row of cells with the first-hit flag rippling upward
  assign hit[0] = 1'b0;
  for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_cell
    entry_t upper;
    if (g == MAX_SLOTS - 1) begin : g_top
      assign upper = cell_entry[g];
    end else begin : g_mid
      assign upper = cell_entry[g+1];
    end
    assign live[g] = (CNT_W'(g) < count_r);
    assign load[g] = commit && (func_r == FN_INSERT) && ins_ok && (CNT_W'(g) == count_r);

    cttbl_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .key         (key_r),
      .live        (live[g]),
      .load        (load[g]),
      .upper_entry (upper),
      .hit_in      (hit[g]),
      .entry       (cell_entry[g]),
      .hit_out     (hit[g+1]),
      .first       (first[g])
    );
  end

  // Encode the first hit and select its entry
  always_comb begin
    hit_idx   = '0;
    hit_entry = '0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      if (first[i]) begin
        hit_idx   = hit_idx | IDX_W'(i);
        hit_entry = hit_entry | cell_entry[i];
      end
    end
  end

  assign ins_ok     = (count_r < usable_cur);
  assign cnt_slot_x = SLOT_XW'(count_r);
  assign idx_slot_x = SLOT_XW'(hit_idx);

  // Sequencer: next state and the result
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    status_nxt    = ST_NONE;
    slot_nxt      = '0;
    found_nxt     = '0;
    out_valid_nxt = out_valid_r && out_stall;

    unique case (state_r)
      SEQ_IDLE: begin
        if (accept) begin
          state_nxt = SEQ_BUSY;
        end
      end
      SEQ_BUSY: begin
        // hold the update while the previous result is still stalled
        if (commit) begin
          state_nxt     = SEQ_IDLE;
          out_valid_nxt = 1'b1;
        end
        unique case (func_r)
          FN_INSERT: begin
            if (ins_ok) begin
              status_nxt = ST_OK;
              slot_nxt   = cnt_slot_x[3:0];
              found_nxt  = key_r;
              count_nxt  = count_r + CNT_W'(1);
            end else begin
              status_nxt = ST_FULL;
            end
          end
          FN_FIND_ID, FN_FIND_OWNER: begin
            if (hit[MAX_SLOTS]) begin
              status_nxt = ST_OK;
              slot_nxt   = idx_slot_x[3:0];
              found_nxt  = hit_entry;
            end
          end
          FN_REMOVE: begin
            if (hit[MAX_SLOTS]) begin
              status_nxt = ST_OK;
              slot_nxt   = idx_slot_x[3:0];
              found_nxt  = hit_entry;
              count_nxt  = count_r - CNT_W'(1);
            end
          end
          FN_HEAD: begin
            if (count_r != '0) begin
              status_nxt = ST_OK;
              found_nxt  = cell_entry[0];
            end
          end
          default: begin
            status_nxt = ST_NONE;
          end
        endcase
        if (!commit) begin
          count_nxt = count_r;
        end
      end
      default: begin
        state_nxt = SEQ_IDLE;
      end
    endcase
  end

  assign cnt_act_x = CMP_W'(count_nxt);
  assign act_nxt   = cnt_act_x[4:0];
  assign empty_nxt = (count_nxt == '0);

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= SEQ_IDLE;
      count_r      <= '0;
      table_size_r <= 5'd16;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr) begin
        table_size_r <= pwdata[4:0];
        if (count_r > usable_new) begin
          count_r <= usable_new;
        end
      end else begin
        count_r <= count_nxt;
      end
    end
  end

  // Capture the item and the result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r          <= in_func;
      key_r.trans_id  <= in_trans_id;
      key_r.owner_tag <= in_owner_tag;
    end
    if (commit) begin
      status_r <= status_nxt;
      slot_r   <= slot_nxt;
      found_r  <= found_nxt;
      act_r    <= act_nxt;
      empty_r  <= empty_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_slot           = slot_r;
  assign out_found_trans_id = found_r.trans_id;
  assign out_found_owner    = found_r.owner_tag;
  assign out_active_count   = act_r;
  assign out_empty_res      = empty_r;

endmodule

// ===== rtl/core/cttbl_cell.sv =====
`timescale 1ns / 1ps

module cttbl_cell
  import cttbl_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  entry_t    key,
  input  logic      live,
  input  logic      load,
  input  entry_t    upper_entry,
  input  logic      hit_in,
  output entry_t    entry,
  output logic      hit_out,
  output logic      first
);

  entry_t entry_r;
  logic   match;

  // Compare the held entry against the key
  always_comb begin
    if (ctl.by_id) begin
      match = ctl.search_en && live && (entry_r.trans_id == key.trans_id);
    end else begin
      match = ctl.search_en && live && (entry_r.owner_tag == key.owner_tag);
    end
  end

  // Pass the any-earlier-hit flag up the row
  assign hit_out = hit_in | match;
  assign first   = match & ~hit_in;
  assign entry   = entry_r;

  // Load a new item, or close the gap left by a removal
  always_ff @(posedge clk) begin
    if (load) begin
      entry_r <= key;
    end else if (ctl.shift && (hit_in || match)) begin
      entry_r <= upper_entry;
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import cttbl_pkg::*;

  localparam int          CYCLE_LIMIT     = 1_000_000;
  localparam int          TABLE_SLOTS     = 16;
  localparam int          PHASE_COUNT     = 10;
  localparam int          PHASE_ITEMS     = 140;
  localparam logic [2:0]  ADDR_TABLE_SIZE = 3'd0;
  // Function codes the block does not define; they must answer "not found"
  localparam logic [2:0]  FN_SPARE_LO     = 3'd5;
  localparam logic [2:0]  FN_SPARE_HI     = 3'd7;

  // One predicted answer of the table
  typedef struct {
    status_t     status;
    logic [3:0]  slot;
    logic [31:0] trans_id;
    logic [15:0] owner;
    logic [4:0]  count;
    logic        empty;
  } table_reply_t;

  // Mirror of the table contents and the replies it owes
  class txn_table_mirror;
    logic [31:0]  ids [TABLE_SLOTS];
    logic [15:0]  owners [TABLE_SLOTS];
    int           live;
    int           size_reg;
    int           errors;
    table_reply_t pending_replies [$];

    function new();
      live = 0;
      size_reg = TABLE_SLOTS;
      errors = 0;
      foreach (ids[i]) begin
        ids[i] = '0;
        owners[i] = '0;
      end
    endfunction

    // Saturate the size register to 1..TABLE_SLOTS
    function int usable_slots();
      if (size_reg < 1) return 1;
      if (size_reg > TABLE_SLOTS) return TABLE_SLOTS;
      return size_reg;
    endfunction

    // Shrinking clamps the live count; growing leaves it alone
    function void write_size(logic [4:0] value);
      size_reg = int'(value);
      if (live > usable_slots()) live = usable_slots();
    endfunction

    // Apply one accepted request and queue the reply it must produce
    function void note_request(logic [2:0] fn, logic [31:0] tid, logic [15:0] tag);
      table_reply_t r;
      int hit;
      r.status = ST_NONE;
      r.slot = '0;
      r.trans_id = '0;
      r.owner = '0;
      hit = -1;
      case (fn)
        FN_INSERT: begin
          if (live < usable_slots()) begin
            r.status = ST_OK;
            r.slot = 4'(live);
            r.trans_id = tid;
            r.owner = tag;
            ids[live] = tid;
            owners[live] = tag;
            live++;
          end else begin
            r.status = ST_FULL;
          end
        end
        FN_FIND_ID, FN_FIND_OWNER, FN_REMOVE: begin
          // first match in slot order
          for (int i = 0; i < live; i++) begin
            if (hit < 0 && ((fn == FN_FIND_ID) ? ids[i] == tid : owners[i] == tag)) hit = i;
          end
          if (hit >= 0) begin
            r.status = ST_OK;
            r.slot = 4'(hit);
            r.trans_id = ids[hit];
            r.owner = owners[hit];
            if (fn == FN_REMOVE) begin
              // close the gap and clear the freed top slot
              for (int i = hit; i < live - 1; i++) begin
                ids[i] = ids[i + 1];
                owners[i] = owners[i + 1];
              end
              live--;
              ids[live] = '0;
              owners[live] = '0;
            end
          end
        end
        FN_HEAD: begin
          if (live > 0) begin
            r.status = ST_OK;
            r.trans_id = ids[0];
            r.owner = owners[0];
          end
        end
        default: ;
      endcase
      r.count = 5'(live);
      r.empty = (live == 0);
      pending_replies.push_back(r);
    endfunction

    function void report(string what, logic [31:0] want, logic [31:0] got);
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      errors++;
    endfunction

    // Compare one delivered reply with the oldest one owed
    function void check_reply(logic [1:0] st, logic [3:0] sl, logic [31:0] tid,
                              logic [15:0] own, logic [4:0] cnt, logic emp);
      table_reply_t want;
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected reply, expected none, actual status %0h slot %0h id %0h",
                 $time, st, sl, tid);
        errors++;
        return;
      end
      want = pending_replies.pop_front();
      if (st !== want.status) report("status", 32'(want.status), 32'(st));
      if (sl !== want.slot) report("slot", 32'(want.slot), 32'(sl));
      if (tid !== want.trans_id) report("found_trans_id", want.trans_id, tid);
      if (own !== want.owner) report("found_owner", 32'(want.owner), 32'(own));
      if (cnt !== want.count) report("active_count", 32'(want.count), 32'(cnt));
      if (emp !== want.empty) report("empty_res", 32'(want.empty), 32'(emp));
    endfunction
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_func = '0;
  logic [31:0] in_trans_id = '0;
  logic [15:0] in_owner_tag = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [3:0]  out_slot;
  logic [31:0] out_found_trans_id;
  logic [15:0] out_found_owner;
  logic [4:0]  out_active_count;
  logic        out_empty_res;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  txn_table_mirror board;
  int          cycle_count = 0;
  int          stall_pct = 0;
  int          stall_hold = 0;
  int          mode_left = 0;

  compacting_transaction_table dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_func            (in_func),
    .in_trans_id        (in_trans_id),
    .in_owner_tag       (in_owner_tag),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_slot           (out_slot),
    .out_found_trans_id (out_found_trans_id),
    .out_found_owner    (out_found_owner),
    .out_active_count   (out_active_count),
    .out_empty_res      (out_empty_res),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // Receiver back-pressure: hold each decision until a random hold counter runs out, change intensity now and then
  always @(posedge clk) begin
    if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
      stall_hold <= $urandom_range(0, 5);
    end
    if (mode_left == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pct <= 0;
        1: stall_pct <= 20;
        2: stall_pct <= 50;
        default: stall_pct <= 85;
      endcase
      mode_left <= $urandom_range(50, 300);
    end else begin
      mode_left <= mode_left - 1;
    end
  end

  // Check every reply taken from the block
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_reply(out_status, out_slot, out_found_trans_id, out_found_owner,
                        out_active_count, out_empty_res);
  end

  // Present one item and hold it until the block takes it
  task automatic send_request(input logic [2:0] fn, input logic [31:0] tid,
                              input logic [15:0] tag);
    in_valid <= 1'b1;
    in_func <= fn;
    in_trans_id <= tid;
    in_owner_tag <= tag;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_request(fn, tid, tag);
  endtask

  // Drop valid for a while with junk on the payload
  task automatic idle_sender(input int cycles);
    in_valid <= 1'b0;
    in_func <= 3'($urandom);
    in_trans_id <= $urandom;
    in_owner_tag <= 16'($urandom);
    repeat (cycles) @(posedge clk);
  endtask

  // Stop sending and wait until every owed reply is back
  task automatic drain_table();
    in_valid <= 1'b0;
    while (board.pending_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_table_size(input logic [4:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_TABLE_SIZE;
    pwdata <= {27'b0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    board.write_size(value);
  endtask

  // Small set of owner tags so that duplicates and hits are common
  function automatic logic [15:0] pool_tag();
    case ($urandom_range(0, 3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(1, 4));
    endcase
  endfunction

  // Pick a random request, mostly keyed on entries that are live
  function automatic void draw_request(input int ins_pct, output logic [2:0] fn,
                                       output logic [31:0] tid, output logic [15:0] tag);
    int pick;
    int slot_i;
    pick = $urandom_range(0, 99);
    slot_i = (board.live > 0) ? $urandom_range(0, board.live - 1) : 0;
    tid = $urandom;
    tag = 16'($urandom);
    if (pick < ins_pct) begin
      fn = FN_INSERT;
      pick = $urandom_range(0, 99);
      if (pick < 15 && board.live > 0) tid = board.ids[slot_i];
      else if (pick < 25) tid = ($urandom_range(0, 1) != 0) ? '1 : '0;
      if ($urandom_range(0, 99) < 45) tag = pool_tag();
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 25) fn = FN_FIND_ID;
      else if (pick < 50) fn = FN_FIND_OWNER;
      else if (pick < 85) fn = FN_REMOVE;
      else if (pick < 95) fn = FN_HEAD;
      else fn = 3'($urandom_range(FN_SPARE_LO, FN_SPARE_HI));
      pick = $urandom_range(0, 99);
      if (pick < 60 && board.live > 0) begin
        tid = board.ids[slot_i];
        tag = board.owners[slot_i];
      end else if (pick < 80) begin
        tid = 32'($urandom_range(0, 3));
        tag = pool_tag();
      end
    end
  endfunction

  initial begin
    int          ins_pct;
    int          burst_left;
    int          gap_max;
    logic [4:0]  size_val;
    logic [2:0]  fn;
    logic [31:0] tid;
    logic [15:0] tag;
    board = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table, unused codes
    send_request(FN_HEAD, 32'h0, 16'h0);
    send_request(FN_FIND_ID, 32'hFFFF_FFFF, 16'h0);
    send_request(FN_FIND_OWNER, 32'h0, 16'hFFFF);
    send_request(FN_REMOVE, 32'h0, 16'h0);
    send_request(FN_SPARE_LO, 32'hFFFF_FFFF, 16'hFFFF);
    send_request(FN_SPARE_HI, 32'h0, 16'h0);
    // Extremes, duplicate owner and duplicate id
    send_request(FN_INSERT, 32'h0, 16'hFFFF);
    send_request(FN_INSERT, 32'hFFFF_FFFF, 16'h0);
    send_request(FN_INSERT, 32'h1234_5678, 16'hFFFF);
    send_request(FN_INSERT, 32'hFFFF_FFFF, 16'h0005);
    send_request(FN_FIND_ID, 32'hFFFF_FFFF, 16'h0);
    send_request(FN_FIND_OWNER, 32'h0, 16'hFFFF);
    send_request(FN_FIND_ID, 32'h0, 16'h0);
    send_request(FN_FIND_ID, 32'h7, 16'h0);
    send_request(FN_FIND_OWNER, 32'h0, 16'h0009);
    // Remove at the bottom shifts the rest down, then remove the top entry
    send_request(FN_REMOVE, 32'h0, 16'hFFFF);
    send_request(FN_HEAD, 32'h0, 16'h0);
    send_request(FN_REMOVE, 32'h0, 16'h0005);
    drain_table();

    // Fill a small table up to full
    write_table_size(5'd3);
    send_request(FN_INSERT, 32'hA5A5_A5A5, 16'h0001);
    send_request(FN_INSERT, 32'h5A5A_5A5A, 16'h0002);
    drain_table();

    // Size zero acts as one slot and clamps the live count
    write_table_size(5'd0);
    send_request(FN_HEAD, 32'h0, 16'h0);
    send_request(FN_INSERT, 32'h1, 16'h1);
    send_request(FN_REMOVE, 32'h0, 16'h0);
    send_request(FN_INSERT, 32'h8000_0001, 16'h8001);
    drain_table();

    // Random phases, each with its own size, insert bias and sender gaps
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      case (ph)
        0: size_val = 5'd16;
        1: size_val = 5'd1;
        2: size_val = 5'd17;
        3: size_val = 5'd6;
        4: size_val = 5'd0;
        5: size_val = 5'd31;
        6: size_val = 5'd2;
        7: size_val = 5'd16;
        default: size_val = 5'($urandom_range(1, 16));
      endcase
      write_table_size(size_val);
      case ($urandom_range(0, 2))
        0: ins_pct = 20;
        1: ins_pct = 40;
        default: ins_pct = 65;
      endcase
      if (ph == 0) ins_pct = 65;
      gap_max = (ph % 3 == 0) ? 0 : $urandom_range(2, 8);
      burst_left = $urandom_range(1, 12);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        draw_request(ins_pct, fn, tid, tag);
        send_request(fn, tid, tag);
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          if (gap_max > 0) idle_sender($urandom_range(1, gap_max));
        end
      end
      drain_table();
    end

    repeat (8) @(posedge clk);
    if (board.errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
